// File: sv/ise_pkg.sv
// Shared types and constants for the insertion sort engine.
`timescale 1ns / 1ps

package ise_pkg;

	localparam int VAL_W = 32;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;   // insert the broadcast value
		logic shift; // move contents one place towards cell 0
	} cell_ctrl_t;

endpackage

// File: sv/ise_cell.sv
// One cell of the sorting chain: holds a single stored value.
`timescale 1ns / 1ps

module ise_cell (
	input  logic              clk,
	input  ise_pkg::cell_ctrl_t ctrl,
	input  ise_pkg::val_t     new_val,
	input  logic              occ,
	input  logic              left_occ,
	input  logic              left_gt,
	input  ise_pkg::val_t     left_val,
	input  ise_pkg::val_t     right_val,
	output logic              gt,
	output ise_pkg::val_t     val
);
	import ise_pkg::*;

	val_t val_q;
	val_t val_nxt;

	assign gt  = occ && (val_q > new_val);
	assign val = val_q;

	always_comb begin
		val_nxt = val_q;
		if (ctrl.shift) begin
			val_nxt = right_val;
		end else if (ctrl.ins) begin
			// occupied and larger: move up; empty tail slot: fill
			if (gt || (!occ && left_occ)) begin
				val_nxt = left_gt ? left_val : new_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

endmodule

// File: sv/insertion_sort_engine.sv
// Top level: streaming insertion sort over a chain of storage cells.
// Insertion: one input transaction per cycle, each value placed in the same cycle.
// After the transaction marked last, results follow from the next cycle, one per cycle
// when m_axis_tready is high, N results for N stored values; input is stalled while the
// store drains. Store capacity DEPTH; values beyond it are dropped and flagged in tuser.
// Reset clears the fill count, overflow flag and state; cell contents are undefined.
`timescale 1ns / 1ps

module insertion_sort_engine #(
	parameter int DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [ise_pkg::VAL_W-1:0] s_axis_tdata,  // [31:0] in_value
	input  logic                      s_axis_tlast,  // is_last
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [ise_pkg::VAL_W-1:0] m_axis_tdata,  // [31:0] out_value
	output logic                      m_axis_tlast,  // out_last
	output logic                      m_axis_tuser   // dropped
);
	import ise_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);
	localparam logic [CW-1:0] ONE  = CW'(1);

	state_t      state_q, state_nxt;
	logic [CW-1:0] count_q, count_nxt;
	logic        ovf_q, ovf_nxt;
	cell_ctrl_t  ctrl;
	val_t        new_val;
	logic        in_acc, out_acc, full;

	logic [DEPTH-1:0] occ;
	logic [DEPTH-1:0] gt;
	val_t             val [DEPTH];

	assign new_val = val_t'(s_axis_tdata);
	assign full    = (count_q == FULL);

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			assign occ[i] = (count_q > CW'(i));
			if (i == 0) begin : g_first
				ise_cell u_cell (
					.clk      (clk),
					.ctrl     (ctrl),
					.new_val  (new_val),
					.occ      (occ[i]),
					.left_occ (1'b1),
					.left_gt  (1'b0),
					.left_val (new_val),
					.right_val(val[i+1]),
					.gt       (gt[i]),
					.val      (val[i])
				);
			end else if (i == DEPTH - 1) begin : g_end
				ise_cell u_cell (
					.clk      (clk),
					.ctrl     (ctrl),
					.new_val  (new_val),
					.occ      (occ[i]),
					.left_occ (occ[i-1]),
					.left_gt  (gt[i-1]),
					.left_val (val[i-1]),
					.right_val(val[i]),
					.gt       (gt[i]),
					.val      (val[i])
				);
			end else begin : g_mid
				ise_cell u_cell (
					.clk      (clk),
					.ctrl     (ctrl),
					.new_val  (new_val),
					.occ      (occ[i]),
					.left_occ (occ[i-1]),
					.left_gt  (gt[i-1]),
					.left_val (val[i-1]),
					.right_val(val[i+1]),
					.gt       (gt[i]),
					.val      (val[i])
				);
			end
		end
	endgenerate

	assign m_axis_tdata = val[0];
	assign m_axis_tlast = (count_q == ONE);
	assign m_axis_tuser = ovf_q;
	assign in_acc       = s_axis_tvalid && s_axis_tready;
	assign out_acc      = m_axis_tvalid && m_axis_tready;

	always_comb begin
		state_nxt     = state_q;
		count_nxt     = count_q;
		ovf_nxt       = ovf_q;
		ctrl          = '0;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		case (state_q)
			ST_FILL: begin
				s_axis_tready = 1'b1;
				if (in_acc) begin
					if (full) begin
						ovf_nxt = 1'b1;
					end else begin
						ctrl.ins  = 1'b1;
						count_nxt = count_q + ONE;
					end
					if (s_axis_tlast) begin
						state_nxt = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				m_axis_tvalid = 1'b1;
				if (out_acc) begin
					ctrl.shift = 1'b1;
					count_nxt  = count_q - ONE;
					if (count_q == ONE) begin
						state_nxt = ST_FILL;
						ovf_nxt   = 1'b0;
					end
				end
			end
			default: begin
				state_nxt = ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			ovf_q   <= ovf_nxt;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("fill count beyond capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (count_q != '0))
		else $error("draining an empty store");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input and output active together");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_axis_tlast) |=> (state_q == ST_FILL && count_q == '0 && !ovf_q))
		else $error("run did not close after last result");

	a_drop_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && full) |=> ovf_q)
		else $error("overflow not recorded");

endmodule

// File: sim/insertion_sort_engine_test.sv
// Testbench for insertion_sort_engine: random sorting runs checked against an in-bench model.
`timescale 1ns / 1ps

module insertion_sort_engine_test;

	import ise_pkg::*;

	localparam int DEPTH = 16;
	localparam int ITEM_TARGET = 280;

	typedef struct {
		val_t value;
		logic last;
		logic hold;
	} in_item_t;

	typedef struct {
		val_t value;
		logic last;
		logic dropped;
	} out_item_t;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [VAL_W-1:0]   s_axis_tdata;   // [31:0] in_value
	logic               s_axis_tlast;   // is_last
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [VAL_W-1:0]   m_axis_tdata;   // [31:0] out_value
	logic               m_axis_tlast;   // out_last
	logic               m_axis_tuser;   // dropped

	in_item_t  pending_items[$];
	out_item_t sorted_results[$];
	val_t      model_store[DEPTH];
	int        model_count;
	logic      model_spill;
	int        mismatch_count;
	int        item_total;
	bit        in_taken;
	int        burst_left;
	int        gap_left;
	int        rx_cycle;
	int        rx_mode;

	insertion_sort_engine #(
		.DEPTH(DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic val_t pick_value(int mode);
		case (mode)
			0: return val_t'($urandom);
			1: return val_t'($urandom_range(8)) - 4;
			default: begin
				case ($urandom_range(5))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh8000_0001;
					3: return 32'sh7fff_fffe;
					4: return 32'sh0000_0000;
					default: return -32'sd1;
				endcase
			end
		endcase
	endfunction

	task automatic add_item(val_t v, bit last, bit hold);
		in_item_t it;
		it.value = v;
		it.last = last;
		it.hold = hold;
		pending_items.push_back(it);
		item_total++;
	endtask

	task automatic add_run(int len, int mode, bit hold);
		for (int i = 0; i < len; i++) begin
			add_item(pick_value(mode == 3 ? $urandom_range(2) : mode), i == len - 1,
				hold && i == 0);
		end
	endtask

	// insert into the model store; a last item flushes the whole run into the result queue
	function automatic void sort_insert(val_t v, logic last);
		int pos;
		out_item_t res;
		if (model_count >= DEPTH) begin
			model_spill = 1'b1;
		end else begin
			pos = model_count;
			while (pos > 0 && model_store[pos-1] > v) begin
				model_store[pos] = model_store[pos-1];
				pos--;
			end
			model_store[pos] = v;
			model_count++;
		end
		if (last) begin
			for (int k = 0; k < model_count; k++) begin
				res.value = model_store[k];
				res.last = (k == model_count - 1);
				res.dropped = model_spill;
				sorted_results.push_back(res);
			end
			model_count = 0;
			model_spill = 1'b0;
		end
	endfunction

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			in_taken = s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				if (sorted_results.size() == 0) begin
					$display("%0t: unexpected transaction value=%0d last=%b dropped=%b",
						$time, $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
					mismatch_count++;
				end else begin
					want = sorted_results.pop_front();
					if (m_axis_tdata !== want.value) begin
						$display("%0t: out_value expected %0d actual %0d",
							$time, want.value, $signed(m_axis_tdata));
						mismatch_count++;
					end
					if (m_axis_tlast !== want.last) begin
						$display("%0t: out_last expected %b actual %b",
							$time, want.last, m_axis_tlast);
						mismatch_count++;
					end
					if (m_axis_tuser !== want.dropped) begin
						$display("%0t: dropped expected %b actual %b",
							$time, want.dropped, m_axis_tuser);
						mismatch_count++;
					end
				end
			end
			if (in_taken)
				sort_insert(val_t'(s_axis_tdata), s_axis_tlast);
		end
	end

	// driver and receiver stall pattern
	always @(negedge clk) begin
		logic next_valid;
		logic next_ready;
		in_item_t it;
		if (arst_n) begin
			next_valid = s_axis_tvalid && !in_taken;
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() > 0 &&
						(!pending_items[0].hold || sorted_results.size() == 0)) begin
					it = pending_items.pop_front();
					s_axis_tdata <= it.value;
					s_axis_tlast <= it.last;
					next_valid = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			s_axis_tvalid <= next_valid;

			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(3);
			case (rx_mode)
				0: next_ready = 1'b1;
				1: next_ready = $urandom_range(1);
				2: next_ready = (rx_cycle % 4 == 0);
				default: next_ready = ($urandom_range(3) == 0);
			endcase
			m_axis_tready <= next_ready;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		model_count = 0;
		model_spill = 1'b0;
		mismatch_count = 0;
		item_total = 0;
		in_taken = 1'b0;
		burst_left = 8;
		gap_left = 0;
		rx_cycle = 0;
		rx_mode = 0;

		// extremes, then a lone minimum after a full drain
		add_item(32'sh7fff_ffff, 1'b0, 1'b0);
		add_item(32'sh8000_0000, 1'b0, 1'b0);
		add_item(32'sh0000_0000, 1'b0, 1'b0);
		add_item(-32'sd1, 1'b1, 1'b0);
		add_item(32'sh8000_0000, 1'b1, 1'b1);
		// descending pairs of equal values past capacity, last pair dropped
		for (int i = 0; i < DEPTH + 2; i++)
			add_item(val_t'(8 - i / 2), i == DEPTH + 1, 1'b0);

		while (item_total < ITEM_TARGET) begin
			case ($urandom_range(9))
				0: add_run($urandom_range(DEPTH + 1, DEPTH + 4), $urandom_range(3),
					$urandom_range(7) == 0);
				1: add_run(DEPTH, $urandom_range(3), $urandom_range(7) == 0);
				default: add_run($urandom_range(1, 12), $urandom_range(3),
					$urandom_range(7) == 0);
			endcase
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do begin
			@(posedge clk);
			#1;
		end while (pending_items.size() != 0 || (s_axis_tvalid && !in_taken) ||
			sorted_results.size() != 0);
		repeat (40) @(posedge clk);

		if (mismatch_count == 0 && sorted_results.size() == 0) begin
			$display("PASS insertion_sort_engine");
		end else begin
			$display("FAIL insertion_sort_engine");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL insertion_sort_engine");
		$finish;
	end

endmodule

// File: insertion_sort_engine.f
sv/ise_pkg.sv
sv/ise_cell.sv
sv/insertion_sort_engine.sv
sim/insertion_sort_engine_test.sv
